### design/mlfd_pkg.sv
// Package with the payload types, codes and controller interface types of the forwarding block.
`default_nettype none

package mlfd_pkg;

    localparam int HOST_ENTRIES_DEF = 64;

    localparam logic [15:0] ET_ARP  = 16'h0806;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86DD;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_FLOOD = 2'd1;
    localparam logic [1:0] ACT_FLOW  = 2'd2;

    localparam logic REQ_PACKET = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [15:0] in_port;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [15:0] ethertype;
        logic [7:0]  ip_proto;
    } req_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] fwd_port;
        logic        learned;
        logic        table_full;
    } res_t;

    typedef struct packed {
        logic [47:0] mac;
        logic [15:0] port;
    } host_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_last;
    } ctrl_sts_t;

endpackage

`default_nettype wire

### design/mlfd_ctrl.sv
// Controller FSM that sequences load, an optional table scan and commit of each transaction.
`default_nettype none

module mlfd_ctrl
    import mlfd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_stall,
    output logic           res_valid,
    input  wire logic      res_stall,
    input  wire ctrl_sts_t sts,
    output ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;

    always_comb
    begin
        cmd.load   = (state_reg == S_IDLE) && req_valid;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.commit = (state_reg == S_DECIDE) && (!res_valid_reg || !res_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.need_scan ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign req_stall = (state_reg != S_IDLE);
    assign res_valid = res_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(res_valid_reg && res_stall))
        else $error("A result was committed over a stalled result.");

    a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(cmd.commit))
        else $error("A result became valid without a commit.");

    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && sts.scan_last) |=> (state_reg == S_DRAIN) && !req_stall == 1'b0)
        else $error("The scan did not end after its last entry.");
`endif

endmodule

`default_nettype wire

### design/mlfd_dpath.sv
// Datapath with the host table memory, the scan compare stage and the result register.
`default_nettype none

module mlfd_dpath
    import mlfd_pkg::*;
#(
    parameter int HOST_ENTRIES = HOST_ENTRIES_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_t      req_data,
    output res_t           res_data,
    input  wire logic      cfg_valid,
    output logic           cfg_ready,
    input  wire logic      cfg_data,
    input  wire ctrl_cmd_t cmd,
    output ctrl_sts_t      sts
);

    localparam int AW = $clog2(HOST_ENTRIES);
    localparam int CW = $clog2(HOST_ENTRIES + 1);

    host_t          mem [HOST_ENTRIES];

    req_t           req_reg;
    res_t           res_reg;
    res_t           res_next;
    host_t          rd_data_reg;
    logic           flood_ipv6_reg;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [AW-1:0]  rd_addr_reg;
    logic [AW-1:0]  rd_addr_next;
    logic           cmp_vld_reg;
    logic           src_hit_reg;
    logic           dst_hit_reg;
    logic [15:0]    dst_port_reg;

    logic           in_lookup;
    logic           is_clear;
    logic           is_arp;
    logic           is_ipv4;
    logic           is_ipv6;
    logic           proto_known;
    logic           tbl_full;
    logic           learn_ok;
    logic           learn_fail;
    logic [15:0]    look_port;

    // Scan only when the table holds entries and the request needs a search.
    always_comb
    begin
        in_lookup = (req_data.ethertype == ET_ARP)
                 || ((req_data.ethertype == ET_IPV4)
                     && (req_data.ip_proto inside {PROTO_ICMP, PROTO_TCP, PROTO_UDP}));
        sts.need_scan = (req_data.req_type == REQ_PACKET) && (count_reg != '0) && in_lookup;
        sts.scan_last = ((CW'(rd_addr_reg) + CW'(1)) == count_reg);
    end

    always_comb
    begin
        is_clear    = (req_reg.req_type == REQ_CLEAR);
        is_arp      = !is_clear && (req_reg.ethertype == ET_ARP);
        is_ipv4     = !is_clear && (req_reg.ethertype == ET_IPV4);
        is_ipv6     = !is_clear && (req_reg.ethertype == ET_IPV6);
        proto_known = req_reg.ip_proto inside {PROTO_ICMP, PROTO_TCP, PROTO_UDP};
        tbl_full    = (count_reg == CW'(HOST_ENTRIES));
        learn_ok    = is_arp && !src_hit_reg && !tbl_full;
        learn_fail  = is_arp && !src_hit_reg && tbl_full;

        // A newly learned source is visible to the destination lookup of the same packet.
        if (dst_hit_reg)
        begin
            look_port = dst_port_reg;
        end
        else if (learn_ok && (req_reg.dst_mac == req_reg.src_mac))
        begin
            look_port = req_reg.in_port;
        end
        else
        begin
            look_port = '0;
        end

        res_next            = '0;
        res_next.learned    = learn_ok;
        res_next.table_full = learn_fail;
        if ((is_arp && !(&req_reg.dst_mac)) || (is_ipv4 && proto_known))
        begin
            if (look_port != '0)
            begin
                res_next.action   = ACT_FLOW;
                res_next.fwd_port = look_port;
            end
        end
        else if (is_arp || is_ipv4 || (is_ipv6 && flood_ipv6_reg))
        begin
            res_next.action = ACT_FLOOD;
        end

        if (is_clear)
        begin
            count_next = '0;
        end
        else if (learn_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end

        rd_addr_next = cmd.load ? '0 : (cmd.scan ? rd_addr_reg + AW'(1) : rd_addr_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && learn_ok)
        begin
            mem[count_reg[AW-1:0]] <= '{mac: req_reg.src_mac, port: req_reg.in_port};
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
        if (cmd.load)
        begin
            dst_port_reg <= '0;
        end
        else if (cmd.load == 1'b0 && cmp_vld_reg && !dst_hit_reg
                 && (rd_data_reg.mac == req_reg.dst_mac))
        begin
            dst_port_reg <= rd_data_reg.port;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flood_ipv6_reg <= 1'b0;
            count_reg      <= '0;
            rd_addr_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            src_hit_reg    <= 1'b0;
            dst_hit_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                flood_ipv6_reg <= cfg_data;
            end
            if (cmd.commit)
            begin
                count_reg <= count_next;
            end
            rd_addr_reg <= rd_addr_next;
            cmp_vld_reg <= cmd.scan;
            if (cmd.load)
            begin
                src_hit_reg <= 1'b0;
                dst_hit_reg <= 1'b0;
            end
            else if (cmp_vld_reg)
            begin
                if (rd_data_reg.mac == req_reg.src_mac)
                begin
                    src_hit_reg <= 1'b1;
                end
                if (rd_data_reg.mac == req_reg.dst_mac)
                begin
                    dst_hit_reg <= 1'b1;
                end
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign res_data  = res_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(HOST_ENTRIES))
        else $error("Host count exceeds the table size.");

    a_learn_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && learn_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("Learning did not advance the host count.");

    a_compare_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_vld_reg |-> $past(cmd.scan))
        else $error("Compare stage active without a preceding table read.");
`endif

endmodule

`default_nettype wire

### design/mac_learning_forward_decision.sv
// When the table is searched, an accepted request goes through the scan state, which reads
// the n host entries held one per cycle, then the drain state and the decide state, whose
// commit registers the result; with no search or an empty table, decide follows the load.
// Commit waits while a stalled result is held; a new request is taken only once the last commits.
// Reset clears the host count, the IPv6 flood setting and all control state; table memory is
// left as is and no clearing pass runs, so the block accepts transactions right after reset.
`default_nettype none

module mac_learning_forward_decision
    import mlfd_pkg::*;
#(
    parameter int HOST_ENTRIES = HOST_ENTRIES_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req_data,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res_data,
    input  wire logic cfg_valid,
    output logic      cfg_ready,
    input  wire logic cfg_data
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    mlfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mlfd_dpath #(
        .HOST_ENTRIES (HOST_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire
